/* rtl/core/efrc_pkg.sv */
// Package for the escaped frame receiver with additive checksum.
// Holds the framing byte codes, escape codes and frame status codes.
// No dependencies.
package efrc_pkg;

  localparam logic [7:0] BYTE_START = 8'hAA;
  localparam logic [7:0] BYTE_END   = 8'hCC;
  localparam logic [7:0] BYTE_ESC   = 8'hBB;
  localparam logic [7:0] ESC_START  = 8'h55;
  localparam logic [7:0] ESC_ESC    = 8'h44;
  localparam logic [7:0] ESC_END    = 8'h33;

  localparam logic [1:0] ST_GOOD   = 2'd0;
  localparam logic [1:0] ST_BADSUM = 2'd1;
  localparam logic [1:0] ST_ABORT  = 2'd2;
  localparam logic [1:0] ST_EMPTY  = 2'd3;

  localparam logic [7:0] ERR_MAX = 8'hFF;

  typedef struct packed {
    logic [7:0] error_count;
    logic [7:0] payload_byte;
  } out_data_t;

endpackage

/* rtl/core/escaped_frame_receiver_checksum.sv */
// Escaped frame receiver: top level and only module of the block.
// Depends on efrc_pkg for byte codes, status codes and the output word type.
//
// Usage:
//   Slave channel s_* takes one raw line byte per request in s_tdata.
//   Master channel m_* returns payload bytes (m_tlast low, m_tuser good)
//   and one status request per closed or aborted frame (m_tlast high,
//   payload zero, m_tuser the frame status). m_tdata carries the error
//   count in its upper byte.
//   Output: a result enters the output register, or the skid register while
//   that one is full, when the byte that caused it is taken; payload bytes are
//   held back by one byte so the last one can be checked as the checksum.
//   Throughput: one byte per cycle while s_tready is high, set by the single
//   register stage of the decode logic; a two-entry output stage (output and
//   skid register) keeps s_tready high while one result waits for m_tready.
//   Reset: synchronous, clears the frame state, the error count and both
//   output entries.
//   Stall: when both output entries are full, s_tready drops until the
//   receiver takes a result.
module escaped_frame_receiver_checksum (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // [7:0] rx_byte
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [15:0] m_tdata,  // [7:0] payload_byte, [15:8] error_count
  output logic       m_tlast,   // frame_end
  output logic [1:0] m_tuser    // [1:0] frame_status
);
  import efrc_pkg::*;

  logic       in_frame, in_frame_next;
  logic       escape_pending, escape_pending_next;
  logic       have_held, have_held_next;
  logic [7:0] held_byte, held_byte_next;
  logic [7:0] running_sum, running_sum_next;
  logic [7:0] errors_seen, errors_seen_next;

  logic       res_valid;
  logic [7:0] res_payload;
  logic       res_end;
  logic [1:0] res_status;
  logic       count_err;
  logic       clear_err;
  logic       data_valid;
  logic [7:0] data_byte;

  logic       skid_valid;
  out_data_t  out_data, skid_data;
  logic       out_last, skid_last;
  logic [1:0] out_user, skid_user;

  logic accept, push, pop;

  assign s_tready = !skid_valid;
  assign accept   = s_tvalid && s_tready;
  assign push     = accept && res_valid;
  assign pop      = m_tvalid && m_tready;

  always_comb begin
    in_frame_next       = in_frame;
    escape_pending_next = escape_pending;
    have_held_next      = have_held;
    held_byte_next      = held_byte;
    running_sum_next    = running_sum;
    res_valid           = 1'b0;
    res_payload         = 8'd0;
    res_end             = 1'b0;
    res_status          = ST_GOOD;
    count_err           = 1'b0;
    clear_err           = 1'b0;
    data_valid          = 1'b0;
    data_byte           = s_tdata;

    if (s_tdata == BYTE_START) begin
      if (in_frame) begin
        count_err  = 1'b1;
        res_valid  = 1'b1;
        res_end    = 1'b1;
        res_status = ST_ABORT;
      end
      in_frame_next       = 1'b1;
      escape_pending_next = 1'b0;
      have_held_next      = 1'b0;
      held_byte_next      = 8'd0;
      running_sum_next    = 8'd0;
    end else if (in_frame) begin
      if (s_tdata == BYTE_END) begin
        in_frame_next       = 1'b0;
        escape_pending_next = 1'b0;
        res_valid           = 1'b1;
        res_end             = 1'b1;
        if (!have_held) begin
          count_err  = 1'b1;
          res_status = ST_EMPTY;
        end else if (running_sum == held_byte) begin
          clear_err  = 1'b1;
          res_status = ST_GOOD;
        end else begin
          count_err  = 1'b1;
          res_status = ST_BADSUM;
        end
        have_held_next   = 1'b0;
        held_byte_next   = 8'd0;
        running_sum_next = 8'd0;
      end else if (!escape_pending) begin
        if (s_tdata == BYTE_ESC) begin
          escape_pending_next = 1'b1;
        end else begin
          data_valid = 1'b1;
        end
      end else begin
        escape_pending_next = 1'b0;
        case (s_tdata)
          ESC_START: begin
            data_valid = 1'b1;
            data_byte  = BYTE_START;
          end
          ESC_ESC: begin
            data_valid = 1'b1;
            data_byte  = BYTE_ESC;
          end
          ESC_END: begin
            data_valid = 1'b1;
            data_byte  = BYTE_END;
          end
          default: count_err = 1'b1;
        endcase
      end
    end

    if (data_valid) begin
      if (have_held) begin
        res_valid        = 1'b1;
        res_payload      = held_byte;
        running_sum_next = running_sum + held_byte;
      end
      held_byte_next = data_byte;
      have_held_next = 1'b1;
    end

    if (clear_err) begin
      errors_seen_next = 8'd0;
    end else if (count_err && errors_seen != ERR_MAX) begin
      errors_seen_next = errors_seen + 8'd1;
    end else begin
      errors_seen_next = errors_seen;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_frame       <= 1'b0;
      escape_pending <= 1'b0;
      have_held      <= 1'b0;
      held_byte      <= 8'd0;
      running_sum    <= 8'd0;
      errors_seen    <= 8'd0;
    end else if (accept) begin
      in_frame       <= in_frame_next;
      escape_pending <= escape_pending_next;
      have_held      <= have_held_next;
      held_byte      <= held_byte_next;
      running_sum    <= running_sum_next;
      errors_seen    <= errors_seen_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid   <= 1'b0;
      skid_valid <= 1'b0;
    end else if (push) begin
      if (!m_tvalid || pop) begin
        m_tvalid <= 1'b1;
      end else begin
        skid_valid <= 1'b1;
      end
    end else if (pop) begin
      if (skid_valid) begin
        skid_valid <= 1'b0;
      end else begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      if (!m_tvalid || pop) begin
        out_data.payload_byte <= res_payload;
        out_data.error_count  <= errors_seen_next;
        out_last              <= res_end;
        out_user              <= res_status;
      end else begin
        skid_data.payload_byte <= res_payload;
        skid_data.error_count  <= errors_seen_next;
        skid_last              <= res_end;
        skid_user              <= res_status;
      end
    end else if (pop && skid_valid) begin
      out_data <= skid_data;
      out_last <= skid_last;
      out_user <= skid_user;
    end
  end

  assign m_tdata = out_data;
  assign m_tlast = out_last;
  assign m_tuser = out_user;

endmodule

/* rtl/core/efrc_checker.sv */
// Port checker for escaped_frame_receiver_checksum, bound to the top level.
// Depends on efrc_pkg for the frame status codes.
module efrc_checker (
  input logic        clk,
  input logic        rst,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [15:0] m_tdata,
  input logic        m_tlast,
  input logic [1:0]  m_tuser
);
  import efrc_pkg::*;

  a_reset_clears_out: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("output valid after reset");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast)
      && $stable(m_tuser))
    else $error("stalled request changed");

  a_status_zero_payload: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tlast |-> m_tdata[7:0] == 8'd0)
    else $error("status request carries payload");

  a_payload_good: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tlast |-> m_tuser == ST_GOOD)
    else $error("payload request carries a status");

  a_good_clears_count: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tlast && m_tuser == ST_GOOD |-> m_tdata[15:8] == 8'd0)
    else $error("good frame left a nonzero error count");

endmodule

bind escaped_frame_receiver_checksum efrc_checker u_efrc_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast),
  .m_tuser  (m_tuser)
);
